>>> hw/rtl/iprl_pkg.sv
// iprl_pkg: shared types and constants of the ip range record lookup block
// no dependencies; used by the core and its checker

package iprl_pkg;

    // prefix table is indexed by the top 16 bits of the address
    localparam int PREFIX_ENTRIES = 65536;
    localparam int PREFIX_W       = 16;

    // default depth of the range record table
    localparam int RECORD_DEPTH_DEF = 65536;

    // field widths
    localparam int OP_W     = 2;
    localparam int TADDR_W  = 16;
    localparam int IP_W     = 32;
    localparam int OFFSET_W = 24;
    localparam int LENGTH_W = 16;
    localparam int COUNT_W  = 17;

    // apb register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_PREFIX = 2'd0,
        OP_LOAD_RECORD = 2'd1,
        OP_LOOKUP      = 2'd2,
        OP_NOP         = 2'd3
    } op_t;

    // register indexes (word address = paddr[2])
    typedef enum logic {
        REG_RECORD_COUNT = 1'b0,
        REG_UNUSED       = 1'b1
    } reg_idx_t;

    // one range record as stored in memory
    typedef struct packed {
        logic [IP_W-1:0]     end_ip;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
    } record_t;

endpackage

>>> hw/rtl/ip_range_record_lookup_core.sv
// ip_range_record_lookup_core: prefix table, range record table and scan sequencer
// depends on iprl_pkg
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready | operation, table address, load data, lookup ip
//  m_      | out       | m_valid / m_ready | found, data_offset, data_length
//  apb     | in/out    | psel/penable      | record_count at byte address 0
//
//  a prefix or record load is written at its accept and leaves s_ready high
//  a lookup reads the prefix table at accept, passes ST_PFX_RD, then for each record
//  steps through ST_SCAN_RD and ST_CMP until a hit or the scan limit, then ST_RESULT;
//  the single read port of the record memory sets one read, then one compare, per record
//  s_ready is low from a lookup accept until its result moves into the output register
//  a stalled result waits in the output register; loads are still taken meanwhile
//  aresetn clears the sequencer, the output valid and record_count; tables are undefined until loaded

module ip_range_record_lookup_core
    import iprl_pkg::*;
#(
    parameter int RECORD_DEPTH = RECORD_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // input beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_operation,
    input  logic [TADDR_W-1:0]    s_table_address,
    input  logic [PREFIX_W-1:0]   s_prefix_first_record,
    input  logic [IP_W-1:0]       s_range_end_ip,
    input  logic [OFFSET_W-1:0]   s_record_data_offset,
    input  logic [LENGTH_W-1:0]   s_record_data_length,
    input  logic [IP_W-1:0]       s_lookup_ip,

    // result beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output logic [OFFSET_W-1:0]   m_data_offset,
    output logic [LENGTH_W-1:0]   m_data_length,

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // record index width and the width in which indexes and limits compare
    localparam int IDX_W   = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
    localparam int DEPTH_W = $clog2(RECORD_DEPTH + 1);
    localparam int CMP_W   = (DEPTH_W > COUNT_W) ? DEPTH_W : COUNT_W;

    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(RECORD_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PFX_RD,
        ST_SCAN_RD,
        ST_CMP,
        ST_RESULT
    } state_t;

    // memories
    logic [PREFIX_W-1:0] pfx_mem [PREFIX_ENTRIES];
    record_t             rec_mem [RECORD_DEPTH];

    logic [PREFIX_W-1:0] pfx_rdata_reg;
    record_t             rec_rdata_reg;

    // control and scan state
    state_t              state_reg;
    logic [COUNT_W-1:0]  record_count_reg;
    logic [CMP_W-1:0]    limit_reg;
    logic [COUNT_W-1:0]  scan_idx_reg;
    logic [IP_W-1:0]     ip_reg;

    // result waiting for the output register
    logic                res_found_reg;
    logic [OFFSET_W-1:0] res_offset_reg;
    logic [LENGTH_W-1:0] res_length_reg;

    // output register
    logic                m_valid_reg;
    logic                m_found_reg;
    logic [OFFSET_W-1:0] m_offset_reg;
    logic [LENGTH_W-1:0] m_length_reg;

    logic                s_beat;
    logic                cfg_wr;
    logic                rec_in_range;
    logic                scan_in_range;
    logic                out_free;
    logic [CMP_W-1:0]    limit_next;

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_beat        = s_valid && s_ready;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign rec_in_range  = CMP_W'(s_table_address) < DEPTH_C;
    assign scan_in_range = CMP_W'(scan_idx_reg) < limit_reg;
    assign out_free      = !m_valid_reg || m_ready;

    // scan stops at the record count or at the table depth, whichever is lower
    assign limit_next = (CMP_W'(record_count_reg) < DEPTH_C) ?
                        CMP_W'(record_count_reg) : DEPTH_C;

    assign pready = 1'b1;
    assign prdata = (reg_idx_t'(paddr[2]) == REG_RECORD_COUNT) ?
                    APB_DATA_W'(record_count_reg) : '0;

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_data_offset = m_offset_reg;
    assign m_data_length = m_length_reg;

    // prefix table: written by prefix loads, read once per lookup at accept
    always_ff @(posedge aclk) begin
        if (s_beat && op_t'(s_operation) == OP_LOAD_PREFIX) begin
            pfx_mem[s_table_address] <= s_prefix_first_record;
        end
        if (s_beat && op_t'(s_operation) == OP_LOOKUP) begin
            pfx_rdata_reg <= pfx_mem[s_lookup_ip[IP_W-1 -: PREFIX_W]];
        end
    end

    // record table: one write port for loads, one read port for the scan
    always_ff @(posedge aclk) begin
        if (s_beat && op_t'(s_operation) == OP_LOAD_RECORD && rec_in_range) begin
            rec_mem[IDX_W'(s_table_address)] <= '{end_ip: s_range_end_ip,
                                                  offset: s_record_data_offset,
                                                  length: s_record_data_length};
        end
        if (state_reg == ST_SCAN_RD && scan_in_range) begin
            rec_rdata_reg <= rec_mem[IDX_W'(scan_idx_reg)];
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_count_reg <= '0;
        end else if (cfg_wr && reg_idx_t'(paddr[2]) == REG_RECORD_COUNT) begin
            record_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // sequencer: prefix read, then one record read and one compare per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // in ST_RESULT the output register is loaded below instead
            if (m_valid_reg && m_ready && state_reg != ST_RESULT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_beat && op_t'(s_operation) == OP_LOOKUP) begin
                        ip_reg    <= s_lookup_ip;
                        limit_reg <= limit_next;
                        state_reg <= ST_PFX_RD;
                    end
                end
                ST_PFX_RD: begin
                    scan_idx_reg <= COUNT_W'(pfx_rdata_reg);
                    state_reg    <= ST_SCAN_RD;
                end
                ST_SCAN_RD: begin
                    if (scan_in_range) begin
                        state_reg <= ST_CMP;
                    end else begin
                        // ran off the end of the valid records
                        res_found_reg  <= 1'b0;
                        res_offset_reg <= '0;
                        res_length_reg <= '0;
                        state_reg      <= ST_RESULT;
                    end
                end
                ST_CMP: begin
                    if (rec_rdata_reg.end_ip >= ip_reg) begin
                        res_found_reg  <= 1'b1;
                        res_offset_reg <= rec_rdata_reg.offset;
                        res_length_reg <= rec_rdata_reg.length;
                        state_reg      <= ST_RESULT;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + COUNT_W'(1);
                        state_reg    <= ST_SCAN_RD;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_found_reg  <= res_found_reg;
                        m_offset_reg <= res_offset_reg;
                        m_length_reg <= res_length_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/iprl_checker.sv
// iprl_checker: port-level assertions for ip_range_record_lookup_core, with its bind
// depends on iprl_pkg and the core's port list

module iprl_checker
    import iprl_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [OP_W-1:0]       s_operation,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_found,
    input logic [OFFSET_W-1:0]   m_data_offset,
    input logic [LENGTH_W-1:0]   m_data_length
);

    // a lookup beat drops s_ready, so the input side is held
    a_lookup_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_LOOKUP |=> !s_ready)
        else $error("input ready right after a lookup beat");

    // loads never produce a result beat
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation != OP_LOOKUP && !m_valid |=> !m_valid)
        else $error("result beat raised by a non-lookup beat");

    // a miss carries zero offset and length
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_data_offset == '0 && m_data_length == '0)
        else $error("miss with nonzero offset or length");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) &&
            $stable(m_data_offset) && $stable(m_data_length))
        else $error("stalled result beat changed");

endmodule

bind ip_range_record_lookup_core iprl_checker u_iprl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_operation   (s_operation),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_found       (m_found),
    .m_data_offset (m_data_offset),
    .m_data_length (m_data_length)
);
